[rtl/vrtd_pkg.sv]
// Package for the vertical ray / triangle depth block.
// Holds the coordinate width, the derived datapath widths, the sign codes and
// the structs passed between the pipeline modules. Depends on nothing.
`default_nettype none
package vrtd_pkg;

    // Coordinate width of every input field and of the depth result.
    localparam int CB  = 24;
    // Translated coordinate, edge product and edge area widths.
    localparam int TW  = CB + 1;
    localparam int PW  = 2 * TW;
    localparam int AW  = PW + 1;
    // Split of an area for the weight multiplications.
    localparam int AL  = AW / 2;
    localparam int AH  = AW - AL;
    localparam int LW  = AL + 1 + CB;
    localparam int HW  = AH + CB;
    // Weighted product, numerator and area-sum widths.
    localparam int WW  = AW + CB;
    localparam int NW  = WW + 2;
    localparam int SW  = AW + 2;
    // Quotient magnitude width and the divider stage count.
    localparam int QB  = CB;
    // Cycles from an accepted request to its result strobe.
    localparam int LAT = 8 + QB;

    // Orientation sign of one edge.
    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } t_sgn;

    // One request: query point and three vertices.
    typedef struct packed {
        logic [CB-1:0] qx;
        logic [CB-1:0] qy;
        logic [CB-1:0] v0x;
        logic [CB-1:0] v0y;
        logic [CB-1:0] v0z;
        logic [CB-1:0] v1x;
        logic [CB-1:0] v1y;
        logic [CB-1:0] v1z;
        logic [CB-1:0] v2x;
        logic [CB-1:0] v2y;
        logic [CB-1:0] v2z;
    } t_req;

    // Edge areas, depths and the inside decision.
    typedef struct packed {
        logic          valid;
        logic          hit;
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        logic [AW-1:0] c;
        logic [CB-1:0] z0;
        logic [CB-1:0] z1;
        logic [CB-1:0] z2;
    } t_areas;

    // Unsigned operands of the division and the result sign.
    typedef struct packed {
        logic          valid;
        logic          hit;
        logic          neg;
        logic [NW-1:0] num;
        logic [SW-1:0] den;
    } t_divin;

    // Quotient magnitude leaving the divider.
    typedef struct packed {
        logic          valid;
        logic          hit;
        logic          neg;
        logic [QB-1:0] q;
    } t_divout;

endpackage
`default_nettype wire

[rtl/vertical_ray_triangle_depth.sv]
// Top level of the vertical ray / triangle depth block.
// Depends on vrtd_pkg, vrtd_front, vrtd_weight and vrtd_div.
//
// Usage:
//   A request (query point plus three vertices, signed Q11.12) is taken at
//   every rising edge with start high and busy low. busy is always low: the
//   block is a fully pipelined datapath and takes one request per cycle.
//   Each request gives one result, o_hit and o_depth, shown for exactly one
//   cycle with o_valid high; o_depth is zero on a miss.
//   From the accepting edge to the result cycle a request passes through
//   three stages of translation, edge products and areas, four stages of
//   weighting and operand magnitudes, 24 divider stages producing one
//   quotient bit each, and the output register. Throughput is one result
//   per cycle. Results leave in request order. The receiver cannot hold
//   results off, so nothing ever waits inside the block.
//   A synchronous reset (i_rst_n low) clears every valid bit; requests in
//   flight are dropped and no result appears until new requests arrive.
`default_nettype none
module vertical_ray_triangle_depth (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [vrtd_pkg::CB-1:0] i_query_x,
    input  wire logic [vrtd_pkg::CB-1:0] i_query_y,
    input  wire logic [vrtd_pkg::CB-1:0] i_v0_x,
    input  wire logic [vrtd_pkg::CB-1:0] i_v0_y,
    input  wire logic [vrtd_pkg::CB-1:0] i_v0_z,
    input  wire logic [vrtd_pkg::CB-1:0] i_v1_x,
    input  wire logic [vrtd_pkg::CB-1:0] i_v1_y,
    input  wire logic [vrtd_pkg::CB-1:0] i_v1_z,
    input  wire logic [vrtd_pkg::CB-1:0] i_v2_x,
    input  wire logic [vrtd_pkg::CB-1:0] i_v2_y,
    input  wire logic [vrtd_pkg::CB-1:0] i_v2_z,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [vrtd_pkg::CB-1:0]      o_depth
);

    vrtd_pkg::t_req    w_req;
    vrtd_pkg::t_areas  w_areas;
    vrtd_pkg::t_divin  w_divin;
    vrtd_pkg::t_divout w_divout;

    logic                    r_valid;
    logic                    r_hit;
    logic [vrtd_pkg::CB-1:0] r_depth;

    // The pipeline never stalls.
    assign busy = 1'b0;

    assign w_req.qx  = i_query_x;
    assign w_req.qy  = i_query_y;
    assign w_req.v0x = i_v0_x;
    assign w_req.v0y = i_v0_y;
    assign w_req.v0z = i_v0_z;
    assign w_req.v1x = i_v1_x;
    assign w_req.v1y = i_v1_y;
    assign w_req.v1z = i_v1_z;
    assign w_req.v2x = i_v2_x;
    assign w_req.v2y = i_v2_y;
    assign w_req.v2z = i_v2_z;

    vrtd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_req   (w_req),
        .o_areas (w_areas)
    );

    vrtd_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_areas (w_areas),
        .o_div   (w_divin)
    );

    vrtd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (w_divin),
        .o_div   (w_divout)
    );

    // Output register: apply the sign, force zero on a miss.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_divout.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= w_divout.hit;
        if (!w_divout.hit) begin
            r_depth <= '0;
        end else if (w_divout.neg) begin
            r_depth <= vrtd_pkg::CB'(-w_divout.q);
        end else begin
            r_depth <= w_divout.q;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_valid && r_hit;
    assign o_depth = r_depth;

    // A miss always reports zero depth.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_depth == '0))
        else $error("miss result with nonzero depth");

    // A hit is only reported together with the result strobe.
    a_hit_strobe: assert property (@(posedge i_clk)
        o_hit |-> o_valid)
        else $error("hit without result strobe");

    // Reset leaves no result strobe behind.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule
`default_nettype wire

[rtl/vrtd_front.sv]
// Front pipeline: translation, edge products and edge areas with signs.
// Three register stages. Depends on vrtd_pkg.
`default_nettype none
module vrtd_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire vrtd_pkg::t_req   i_req,
    output vrtd_pkg::t_areas      o_areas
);

    // Stage 1 registers: translated vertices.
    logic                           r_v1;
    logic signed [vrtd_pkg::TW-1:0] r_x [3];
    logic signed [vrtd_pkg::TW-1:0] r_y [3];
    logic        [vrtd_pkg::CB-1:0] r_z1 [3];

    // Stage 2 registers: edge products and tie signs.
    logic                           r_v2;
    logic signed [vrtd_pkg::PW-1:0] r_m1 [3];
    logic signed [vrtd_pkg::PW-1:0] r_m2 [3];
    vrtd_pkg::t_sgn                 r_tie [3];
    logic        [vrtd_pkg::CB-1:0] r_z2 [3];

    // Stage 3 register: areas and hit.
    vrtd_pkg::t_areas               r_out;

    logic signed [vrtd_pkg::TW-1:0] n_x [3];
    logic signed [vrtd_pkg::TW-1:0] n_y [3];
    logic        [vrtd_pkg::CB-1:0] w_vx [3];
    logic        [vrtd_pkg::CB-1:0] w_vy [3];
    logic        [vrtd_pkg::CB-1:0] w_vz [3];
    logic signed [vrtd_pkg::PW-1:0] n_m1 [3];
    logic signed [vrtd_pkg::PW-1:0] n_m2 [3];
    vrtd_pkg::t_sgn                 n_tie [3];
    logic signed [vrtd_pkg::AW-1:0] n_area [3];
    vrtd_pkg::t_sgn                 n_sgn [3];

    assign w_vx[0] = i_req.v0x;
    assign w_vy[0] = i_req.v0y;
    assign w_vz[0] = i_req.v0z;
    assign w_vx[1] = i_req.v1x;
    assign w_vy[1] = i_req.v1y;
    assign w_vz[1] = i_req.v1z;
    assign w_vx[2] = i_req.v2x;
    assign w_vy[2] = i_req.v2y;
    assign w_vz[2] = i_req.v2z;

    // Translate each vertex so the query point is the origin.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_x[k] = $signed({w_vx[k][vrtd_pkg::CB-1], w_vx[k]})
                   - $signed({i_req.qx[vrtd_pkg::CB-1], i_req.qx});
            n_y[k] = $signed({w_vy[k][vrtd_pkg::CB-1], w_vy[k]})
                   - $signed({i_req.qy[vrtd_pkg::CB-1], i_req.qy});
        end
    end

    // Edge k runs from vertex (k+1)%3 to vertex (k+2)%3; form both products
    // and the sign that applies when the area comes out zero.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_m1[k] = r_y[(k+1)%3] * r_x[(k+2)%3];
            n_m2[k] = r_x[(k+1)%3] * r_y[(k+2)%3];
            if (r_y[(k+2)%3] > r_y[(k+1)%3]) begin
                n_tie[k] = vrtd_pkg::SGN_POS;
            end else if (r_y[(k+2)%3] < r_y[(k+1)%3]) begin
                n_tie[k] = vrtd_pkg::SGN_NEG;
            end else if (r_x[(k+1)%3] > r_x[(k+2)%3]) begin
                n_tie[k] = vrtd_pkg::SGN_POS;
            end else if (r_x[(k+1)%3] < r_x[(k+2)%3]) begin
                n_tie[k] = vrtd_pkg::SGN_NEG;
            end else begin
                n_tie[k] = vrtd_pkg::SGN_ZERO;
            end
        end
    end

    // Edge areas and their signs.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_area[k] = $signed({r_m1[k][vrtd_pkg::PW-1], r_m1[k]})
                      - $signed({r_m2[k][vrtd_pkg::PW-1], r_m2[k]});
            if (n_area[k] == '0) begin
                n_sgn[k] = r_tie[k];
            end else if (n_area[k][vrtd_pkg::AW-1]) begin
                n_sgn[k] = vrtd_pkg::SGN_NEG;
            end else begin
                n_sgn[k] = vrtd_pkg::SGN_POS;
            end
        end
    end

    // Pipeline registers; only the valid bits are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_out.valid <= r_v2;
        end
        for (int k = 0; k < 3; k++) begin
            r_x[k]  <= n_x[k];
            r_y[k]  <= n_y[k];
            r_z1[k] <= w_vz[k];
            r_m1[k] <= n_m1[k];
            r_m2[k] <= n_m2[k];
            r_tie[k] <= n_tie[k];
            r_z2[k] <= r_z1[k];
        end
        r_out.hit <= (n_sgn[0] != vrtd_pkg::SGN_ZERO) && (n_sgn[1] == n_sgn[0])
                  && (n_sgn[2] == n_sgn[0]);
        r_out.a   <= n_area[0];
        r_out.b   <= n_area[1];
        r_out.c   <= n_area[2];
        r_out.z0  <= r_z2[0];
        r_out.z1  <= r_z2[1];
        r_out.z2  <= r_z2[2];
    end

    assign o_areas = r_out;

endmodule
`default_nettype wire

[rtl/vrtd_weight.sv]
// Weight pipeline: area-weighted depth sum, area sum and operand magnitudes.
// Four register stages. Depends on vrtd_pkg.
`default_nettype none
module vrtd_weight (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire vrtd_pkg::t_areas i_areas,
    output vrtd_pkg::t_divin      o_div
);

    logic                           r_v4, r_v5, r_v6;
    logic                           r_h4, r_h5, r_h6;
    logic signed [vrtd_pkg::LW-1:0] r_lo [3];
    logic signed [vrtd_pkg::HW-1:0] r_hi [3];
    logic signed [vrtd_pkg::SW-1:0] r_sum4, r_sum5, r_sum6;
    logic signed [vrtd_pkg::WW-1:0] r_w [3];
    logic signed [vrtd_pkg::NW-1:0] r_num;
    vrtd_pkg::t_divin               r_out;

    logic        [vrtd_pkg::AW-1:0] w_a [3];
    logic        [vrtd_pkg::CB-1:0] w_z [3];
    logic signed [vrtd_pkg::LW-1:0] n_lo [3];
    logic signed [vrtd_pkg::HW-1:0] n_hi [3];
    logic signed [vrtd_pkg::SW-1:0] n_sum;
    logic signed [vrtd_pkg::WW-1:0] n_w [3];
    logic signed [vrtd_pkg::NW-1:0] n_num;

    assign w_a[0] = i_areas.a;
    assign w_a[1] = i_areas.b;
    assign w_a[2] = i_areas.c;
    assign w_z[0] = i_areas.z0;
    assign w_z[1] = i_areas.z1;
    assign w_z[2] = i_areas.z2;

    // Each area times its depth as two partial products, plus the area sum.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lo[k] = $signed({1'b0, w_a[k][vrtd_pkg::AL-1:0]}) * $signed(w_z[k]);
            n_hi[k] = $signed(w_a[k][vrtd_pkg::AW-1:vrtd_pkg::AL]) * $signed(w_z[k]);
        end
        n_sum = $signed({{2{w_a[0][vrtd_pkg::AW-1]}}, w_a[0]})
              + $signed({{2{w_a[1][vrtd_pkg::AW-1]}}, w_a[1]})
              + $signed({{2{w_a[2][vrtd_pkg::AW-1]}}, w_a[2]});
    end

    // Recombine the partial products, then add the three weighted depths.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_w[k] = $signed({r_hi[k], {vrtd_pkg::AL{1'b0}}})
                   + $signed({{(vrtd_pkg::WW-vrtd_pkg::LW){r_lo[k][vrtd_pkg::LW-1]}},
                              r_lo[k]});
        end
        n_num = $signed({{2{r_w[0][vrtd_pkg::WW-1]}}, r_w[0]})
              + $signed({{2{r_w[1][vrtd_pkg::WW-1]}}, r_w[1]})
              + $signed({{2{r_w[2][vrtd_pkg::WW-1]}}, r_w[2]});
    end

    // Pipeline registers; only the valid bits are reset, and a zero area
    // sum counts as a miss.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_v4        <= i_areas.valid;
            r_v5        <= r_v4;
            r_v6        <= r_v5;
            r_out.valid <= r_v6;
        end
        for (int k = 0; k < 3; k++) begin
            r_lo[k] <= n_lo[k];
            r_hi[k] <= n_hi[k];
            r_w[k]  <= n_w[k];
        end
        r_h4      <= i_areas.hit;
        r_sum4    <= n_sum;
        r_h5      <= r_h4;
        r_sum5    <= r_sum4;
        r_h6      <= r_h5 && (r_sum5 != '0);
        r_sum6    <= r_sum5;
        r_num     <= n_num;
        r_out.hit <= r_h6;
        r_out.neg <= r_num[vrtd_pkg::NW-1] ^ r_sum6[vrtd_pkg::SW-1];
        r_out.num <= r_num[vrtd_pkg::NW-1] ? vrtd_pkg::NW'(-r_num) : r_num;
        r_out.den <= r_sum6[vrtd_pkg::SW-1] ? vrtd_pkg::SW'(-r_sum6) : r_sum6;
    end

    assign o_div = r_out;

endmodule
`default_nettype wire

[rtl/vrtd_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on vrtd_pkg.
`default_nettype none
module vrtd_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire vrtd_pkg::t_divin i_div,
    output vrtd_pkg::t_divout     o_div
);

    // Entry j holds the output of divider stage j-1.
    logic                          r_v   [1:vrtd_pkg::QB];
    logic                          r_hit [1:vrtd_pkg::QB];
    logic                          r_neg [1:vrtd_pkg::QB];
    logic [vrtd_pkg::NW-1:0]       r_rem [1:vrtd_pkg::QB-1];
    logic [vrtd_pkg::SW-1:0]       r_den [1:vrtd_pkg::QB-1];
    logic [vrtd_pkg::QB-1:0]       r_q   [1:vrtd_pkg::QB];

    for (genvar j = 0; j < vrtd_pkg::QB; j++) begin : g_stage
        localparam int BIT = vrtd_pkg::QB - 1 - j;
        logic                    w_v_in;
        logic                    w_hit_in;
        logic                    w_neg_in;
        logic [vrtd_pkg::NW-1:0] w_rem_in;
        logic [vrtd_pkg::SW-1:0] w_den_in;
        logic [vrtd_pkg::QB-1:0] w_q_in;
        logic [vrtd_pkg::NW-1:0] w_trial;
        logic                    w_ge;

        // The first stage takes the registered operand set from the weight
        // pipeline; every later stage takes the previous stage.
        if (j == 0) begin : g_first
            assign w_v_in   = i_div.valid;
            assign w_hit_in = i_div.hit;
            assign w_neg_in = i_div.neg;
            assign w_rem_in = i_div.num;
            assign w_den_in = i_div.den;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_v_in   = r_v[j];
            assign w_hit_in = r_hit[j];
            assign w_neg_in = r_neg[j];
            assign w_rem_in = r_rem[j];
            assign w_den_in = r_den[j];
            assign w_q_in   = r_q[j];
        end

        // Compare the remainder with the divisor aligned to this bit.
        assign w_trial = {{(vrtd_pkg::NW-vrtd_pkg::SW){1'b0}}, w_den_in} << BIT;
        assign w_ge    = (w_rem_in >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_hit[j+1] <= w_hit_in;
            r_neg[j+1] <= w_neg_in;
            r_q[j+1]   <= w_q_in | (w_ge ? (vrtd_pkg::QB'(1) << BIT) : '0);
        end

        // The last stage needs no remainder or divisor after it.
        if (j < vrtd_pkg::QB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_den[j+1] <= w_den_in;
                r_rem[j+1] <= w_ge ? (w_rem_in - w_trial) : w_rem_in;
            end
        end
    end

    assign o_div.valid = r_v[vrtd_pkg::QB];
    assign o_div.hit   = r_hit[vrtd_pkg::QB];
    assign o_div.neg   = r_neg[vrtd_pkg::QB];
    assign o_div.q     = r_q[vrtd_pkg::QB];

endmodule
`default_nettype wire
